@@ rtl/bca_pkg.sv @@
// Shared constants and types for the centred boxcar averager.
package bca_pkg;

  localparam int AVG_BITS      = 24;
  localparam int FRAC_BITS     = 8;
  localparam int WL_BITS       = 6;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [WL_BITS-1:0] WL_RESET = 6'd5;

  // register index, taken from paddr above the byte-lane bits
  typedef logic reg_idx_t;
  localparam reg_idx_t REG_WINDOW_LENGTH = 1'b0;

  // shared adder/subtractor operation
  typedef logic alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

endpackage

@@ rtl/bca_ring.sv @@
// Sample ring memory: one write port, one registered read port.
module bca_ring #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/bca_alu.sv @@
// Shared adder/subtractor used for accumulation, negation and division steps.
module bca_alu #(
  parameter int W = 21
) (
  input  bca_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W:0]       res
);

  logic [W:0] a_x;
  logic [W:0] b_x;

  assign a_x = {a[W-1], a};
  assign b_x = {b[W-1], b};

  always_comb begin
    if (op == bca_pkg::ALU_SUB) begin
      res = a_x - b_x;
    end else begin
      res = a_x + b_x;
    end
  end

endmodule

@@ rtl/centered_boxcar_average.sv @@
// Centred boxcar average with edge replication: samples in, Q.8 averages out.
// Input channel: in_sample / in_is_last, taken when in_valid is high and
// in_stall low. in_stall is high while an item is being worked on.
// Output channel: out_average / out_run_end / out_series_end, one result per
// transaction, held in an output register until out_stall is low.
// Each sample causes at most one result, except the flagged last sample,
// which flushes every pending result of the series in order.
// Per result the sequencer runs the shared adder to sum the window out of
// the ring memory (one read a cycle), then takes the magnitude, then runs a
// restoring division of the sum, widened by eight fraction bits, by k (one
// quotient bit a cycle), then loads the output register. A sample that
// causes no result leaves the sequencer idle.
// A new sample is taken as soon as the sequencer is idle, even while the
// last result still waits in the output register; a stalled receiver holds
// the sequencer only when a further result is ready to load.
// Reset (rst_n low, synchronous) empties the series, clears the output
// valid flag and sets window_length to 5. The ring needs no clearing pass.
module centered_boxcar_average #(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [SAMPLE_BITS-1:0]             in_sample,
  input  logic                               in_is_last,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bca_pkg::AVG_BITS-1:0]       out_average,
  output logic                               out_run_end,
  output logic                               out_series_end,
  // configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bca_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [bca_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic [bca_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                               cfg_pready
);

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int KW   = $clog2(MAX_WINDOW + 1);
  localparam int SW   = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int DW   = SW + bca_pkg::FRAC_BITS;
  localparam int QW   = (DW > bca_pkg::AVG_BITS) ? DW : bca_pkg::AVG_BITS;
  localparam int CW   = $clog2(DW + 1);
  localparam int AGW  = KW + 3;
  localparam int CMPW = (KW > bca_pkg::WL_BITS) ? KW : bca_pkg::WL_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_NEG  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  // control state
  logic [2:0]                    state_r, state_nxt;
  logic [bca_pkg::WL_BITS-1:0]   window_r;
  logic [KW-1:0]                 seen_r, seen_nxt;
  logic [AW-1:0]                 wr_pos_r, wr_pos_nxt;
  logic                          rd_vld_r;
  logic                          out_valid_r, out_valid_nxt;

  // working registers
  logic [SAMPLE_BITS-1:0]        first_r;
  logic [KW-1:0]                 k_r, h_r, e_r, bottom_r, t_r;
  logic                          last_r;
  logic                          rd_first_r;
  logic [SW-1:0]                 acc_r;
  logic                          neg_r;
  logic [DW-1:0]                 dvd_r;
  logic [KW-1:0]                 rem_r;
  logic [CW-1:0]                 cnt_r;
  logic [bca_pkg::AVG_BITS-1:0]  avg_r;
  logic                          run_end_r, series_end_r;

  // accept-time decode
  logic                          in_acc;
  logic [CMPW-1:0]               wl_ext;
  logic [KW-1:0]                 k_c, h_c, ahead_c, newest_c, top_c, bottom_c;
  logic                          emit_c;

  // ring addressing
  logic                          issue;
  logic signed [AGW-1:0]         age_s, age_c, oldest_s, idx_s, idx_w;
  logic                          use_first_c;
  logic [AW-1:0]                 rd_addr;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic [SAMPLE_BITS-1:0]        term;

  // shared unit
  bca_pkg::alu_op_t              alu_op;
  logic [SW-1:0]                 alu_a, alu_b;
  logic [SW:0]                   alu_res;
  logic [KW:0]                   rem_sh;

  logic [QW-1:0]                 q_ext, sval;
  logic                          out_ld;
  logic                          cfg_wr;

  // ---------------------------------------------------------------- config
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == bca_pkg::REG_WINDOW_LENGTH) begin
      cfg_prdata = bca_pkg::CFG_DATA_BITS'(window_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= bca_pkg::WL_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == bca_pkg::REG_WINDOW_LENGTH)) begin
      window_r <= cfg_pwdata[bca_pkg::WL_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------- accept
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign wl_ext = CMPW'(window_r);

  always_comb begin
    if (window_r == '0) begin
      k_c = KW'(1);
    end else if (wl_ext > CMPW'(MAX_WINDOW)) begin
      k_c = KW'(MAX_WINDOW);
    end else begin
      k_c = KW'(wl_ext);
    end
    h_c     = (k_c - KW'(1)) >> 1;
    ahead_c = k_c - KW'(1) - h_c;
    newest_c = seen_nxt - KW'(1);
    if (in_is_last) begin
      top_c    = (newest_c < ahead_c) ? newest_c : ahead_c;
      bottom_c = '0;
      emit_c   = 1'b1;
    end else begin
      top_c    = ahead_c;
      bottom_c = ahead_c;
      emit_c   = (newest_c >= ahead_c);
    end
  end

  always_comb begin
    seen_nxt   = seen_r;
    wr_pos_nxt = wr_pos_r;
    if (in_acc) begin
      if (seen_r < KW'(MAX_WINDOW)) begin
        seen_nxt = seen_r + KW'(1);
      end
      wr_pos_nxt = (wr_pos_r == AW'(MAX_WINDOW - 1)) ? '0 : wr_pos_r + AW'(1);
    end else if (state_r == S_PUT && out_ld && e_r == bottom_r && last_r) begin
      // series over: start afresh
      seen_nxt   = '0;
      wr_pos_nxt = '0;
    end
  end

  // ---------------------------------------------------------------- ring
  // age of the tap relative to the newest sample, clamped at both edges
  always_comb begin
    age_s    = $signed(AGW'(e_r)) + $signed(AGW'(h_r)) - $signed(AGW'(t_r));
    age_c    = age_s[AGW-1] ? '0 : age_s;
    oldest_s = $signed(AGW'(seen_r)) - $signed(AGW'(1));
    use_first_c = (age_c > oldest_s);
    idx_s    = $signed(AGW'(wr_pos_r)) - $signed(AGW'(1)) - age_c;
    idx_w    = idx_s[AGW-1] ? (idx_s + $signed(AGW'(MAX_WINDOW))) : idx_s;
    rd_addr  = idx_w[AW-1:0];
  end

  assign issue = (state_r == S_ACC) && (t_r != k_r);

  bca_ring #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wr_pos_r),
    .wr_data (in_sample),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign term = rd_first_r ? first_r : rd_data;

  // ---------------------------------------------------------------- shared unit
  assign rem_sh = {rem_r, dvd_r[DW-1]};

  always_comb begin
    alu_op = bca_pkg::ALU_ADD;
    alu_a  = acc_r;
    alu_b  = '0;
    unique case (state_r)
      S_ACC: begin
        alu_op = bca_pkg::ALU_ADD;
        alu_a  = acc_r;
        alu_b  = {{(SW-SAMPLE_BITS){term[SAMPLE_BITS-1]}}, term};
      end
      S_NEG: begin
        alu_op = bca_pkg::ALU_SUB;
        alu_a  = '0;
        alu_b  = acc_r;
      end
      S_DIV: begin
        alu_op = bca_pkg::ALU_SUB;
        alu_a  = SW'(rem_sh);
        alu_b  = SW'(k_r);
      end
      default: begin
        alu_op = bca_pkg::ALU_ADD;
      end
    endcase
  end

  bca_alu #(
    .W (SW)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // ---------------------------------------------------------------- result
  assign q_ext  = QW'(dvd_r);
  assign sval   = neg_r ? (QW'(0) - q_ext) : q_ext;
  assign out_ld = (state_r == S_PUT) && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && emit_c) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (t_r == k_r && !rd_vld_r) begin
          state_nxt = S_NEG;
        end
      end
      S_NEG: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cnt_r == CW'(DW - 1)) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (out_ld) begin
          state_nxt = (e_r == bottom_r) ? S_IDLE : S_ACC;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      wr_pos_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      wr_pos_r    <= wr_pos_nxt;
      rd_vld_r    <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= use_first_c;
    if (issue) begin
      t_r <= t_r + KW'(1);
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (seen_r == '0) begin
            first_r <= in_sample;
          end
          k_r      <= k_c;
          h_r      <= h_c;
          e_r      <= top_c;
          bottom_r <= bottom_c;
          last_r   <= in_is_last;
          t_r      <= '0;
          acc_r    <= '0;
        end
      end
      S_ACC: begin
        if (rd_vld_r) begin
          acc_r <= alu_res[SW-1:0];
        end
      end
      S_NEG: begin
        neg_r <= acc_r[SW-1];
        dvd_r <= {(acc_r[SW-1] ? alu_res[SW-1:0] : acc_r),
                  {bca_pkg::FRAC_BITS{1'b0}}};
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        // restoring step: keep the difference when it did not go negative
        if (!alu_res[SW]) begin
          rem_r <= alu_res[KW-1:0];
          dvd_r <= {dvd_r[DW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[KW-1:0];
          dvd_r <= {dvd_r[DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + CW'(1);
      end
      S_PUT: begin
        if (out_ld) begin
          e_r   <= e_r - KW'(1);
          t_r   <= '0;
          acc_r <= '0;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      avg_r        <= sval[bca_pkg::AVG_BITS-1:0];
      run_end_r    <= (e_r == bottom_r);
      series_end_r <= (e_r == bottom_r) && last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_average    = avg_r;
  assign out_run_end    = run_end_r;
  assign out_series_end = series_end_r;

`ifndef SYNTHESIS
  a_load_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUT))
    else $error("result register loaded outside the output step");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (k_r >= KW'(1) && k_r <= KW'(MAX_WINDOW)))
    else $error("window length out of range while busy");

  a_rem_below_k: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < k_r))
    else $error("division remainder not below divisor");

  a_series_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && series_end_r) |-> run_end_r)
    else $error("series end without run end");
`endif

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the centred boxcar averager, with its scoreboard.
`timescale 1ns / 1ps

module tb_top;

  localparam int RING_DEPTH = 32;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [bca_pkg::AVG_BITS-1:0] average;
    logic                         run_end;
    logic                         series_end;
  } boxcar_result_t;

  // Tracks the series state and predicts the Q.8 averages each sample releases
  class boxcar_scoreboard;
    logic signed [15:0]          ring [RING_DEPTH];
    logic signed [15:0]          first_smp;
    logic [bca_pkg::WL_BITS-1:0] wlen;
    int                          wr_pos;
    int                          seen;
    int                          errors;
    boxcar_result_t              pending_avgs [$];

    function new();
      foreach (ring[i]) ring[i] = '0;
      first_smp = '0;
      wlen = bca_pkg::WL_RESET;
      wr_pos = 0;
      seen = 0;
      errors = 0;
    endfunction

    function logic signed [15:0] aged(int age);
      int a;
      a = (age < 0) ? 0 : age;
      if (a > seen - 1) return first_smp;
      return ring[(wr_pos + RING_DEPTH - 1 - a) % RING_DEPTH];
    endfunction

    function void note_sample(logic [15:0] smp, logic last);
      int k, h, ahead, newest, top, bottom, e, t, sum, quot;
      boxcar_result_t r;
      k = int'(wlen);
      if (k < 1) k = 1;
      if (k > RING_DEPTH) k = RING_DEPTH;
      h = (k - 1) / 2;
      ahead = k - 1 - h;
      if (seen == 0) first_smp = smp;
      ring[wr_pos] = smp;
      wr_pos = (wr_pos + 1) % RING_DEPTH;
      if (seen < RING_DEPTH) seen++;
      newest = seen - 1;
      if (last) begin
        top = (newest < ahead) ? newest : ahead;
        bottom = 0;
      end else begin
        top = ahead;
        bottom = (newest >= ahead) ? ahead : ahead + 1;
      end
      // e counts how far the output position lags the newest sample
      for (e = top; e >= bottom; e--) begin
        sum = 0;
        for (t = 0; t < k; t++) sum += aged(e + h - t);
        quot = (sum * 256) / k;
        r.average = quot[bca_pkg::AVG_BITS-1:0];
        r.run_end = (e == bottom);
        r.series_end = last && (e == bottom);
        pending_avgs.push_back(r);
      end
      if (last) begin
        wr_pos = 0;
        seen = 0;
      end
    endfunction

    function void check_result(logic [bca_pkg::AVG_BITS-1:0] avg, logic run_end,
                               logic series_end);
      boxcar_result_t r;
      if (pending_avgs.size() == 0) begin
        $error("unexpected result: average %0d", $signed(avg));
        errors++;
        return;
      end
      r = pending_avgs.pop_front();
      if (avg !== r.average) begin
        $error("average: expected %0d, got %0d", $signed(r.average), $signed(avg));
        errors++;
      end
      if (run_end !== r.run_end) begin
        $error("run_end: expected %0b, got %0b", r.run_end, run_end);
        errors++;
      end
      if (series_end !== r.series_end) begin
        $error("series_end: expected %0b, got %0b", r.series_end, series_end);
        errors++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [15:0]                       in_sample;
  logic                              in_is_last;
  logic                              out_valid;
  logic                              out_stall;
  logic [bca_pkg::AVG_BITS-1:0]      out_average;
  logic                              out_run_end;
  logic                              out_series_end;
  logic                              cfg_psel;
  logic                              cfg_penable;
  logic                              cfg_pwrite;
  logic [bca_pkg::CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [bca_pkg::CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [bca_pkg::CFG_DATA_BITS-1:0] cfg_prdata;
  logic                              cfg_pready;

  boxcar_scoreboard sb;
  bit               quiet;
  int               fed;

  centered_boxcar_average dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_average    (out_average),
    .out_run_end    (out_run_end),
    .out_series_end (out_series_end),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 27);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_average, out_run_end, out_series_end);
  end

  task automatic push_sample(input logic [15:0] smp, input logic last);
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= smp;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    sb.note_sample(smp, last);
    fed++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending_avgs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_window(input logic [bca_pkg::WL_BITS-1:0] w);
    in_valid <= 1'b0;
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {bca_pkg::REG_WINDOW_LENGTH, 2'b00};
    cfg_pwdata <= bca_pkg::CFG_DATA_BITS'(w);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.wlen = w;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n_series, len, s, j;
    bit leave_open;
    logic [bca_pkg::WL_BITS-1:0] w;

    sb = new();
    quiet = 1'b0;
    fed = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_is_last = 1'b0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset window of 5: a series shorter than the look-ahead, a lone sample, extremes
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h5555, 1'b0);
    push_sample(16'haaaa, 1'b1);
    // zero window acts as one
    program_window('0);
    push_sample(16'h1234, 1'b0);
    push_sample(16'hffff, 1'b1);
    // oversize window, then shrunk part way through the series
    program_window(6'd63);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h8000, 1'b0);
    program_window(6'd2);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h0001, 1'b1);
    program_window(6'd32);
    for (j = 0; j < 6; j++) push_sample(rand_sample(), j == 5);
    program_window(6'd1);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7fff, 1'b1);

    fed = 0;
    while (fed < 320) begin
      case ($urandom_range(9))
        0: w = '0;
        1: w = 6'($urandom_range(33, 63));
        default: w = 6'($urandom_range(1, 32));
      endcase
      program_window(w);
      n_series = $urandom_range(1, 4);
      leave_open = ($urandom_range(4) == 0);
      for (s = 0; s < n_series; s++) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (j = 0; j < len; j++) begin
          // long burst with no idling on either side
          quiet = (fed >= 100) && (fed < 180);
          push_sample(rand_sample(), (j == len - 1) && !(leave_open && s == n_series - 1));
        end
      end
    end
    push_sample(rand_sample(), 1'b1);
    in_valid <= 1'b0;
    wait_drained();

    if (sb.errors == 0 && sb.pending_avgs.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
